// ===== design/lpri_pkg.sv =====
`timescale 1ns / 1ps

package lpri_pkg;

	localparam int CORDIC_STEPS = 23;
	localparam int ANG_W        = 26;
	localparam int PRE_SH       = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd2;

	typedef logic signed [ANG_W-1:0] ang_t;

	// atan(2^-i) in 1/65536 degree
	localparam ang_t ATAN_TAB [CORDIC_STEPS] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
		26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
		26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229,
		26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7,
		26'sd4, 26'sd2, 26'sd1
	};

endpackage

// ===== design/lpri_isqrt.sv =====
`timescale 1ns / 1ps

module lpri_isqrt #(
	parameter int CB = 24,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*CB-1:0] radicand,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [CB-1:0]   root,
	output logic [SW-1:0]   out_side
);

	logic            vld_s  [CB];
	logic [2*CB-1:0] val_s  [CB];
	logic [CB+1:0]   rem_s  [CB];
	logic [CB-1:0]   root_s [CB];
	logic [SW-1:0]   side_s [CB];

	for (genvar k = 0; k < CB; k++) begin : g_stage
		logic            p_vld;
		logic [2*CB-1:0] p_val;
		logic [CB+1:0]   p_rem;
		logic [CB-1:0]   p_root;
		logic [SW-1:0]   p_side;
		logic [CB+1:0]   t_rem;
		logic [CB+1:0]   trial;

		if (k == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_val  = radicand;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_val  = val_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_side = side_s[k-1];
		end

		assign t_rem = {p_rem[CB-1:0], p_val[2*CB-1 -: 2]};
		assign trial = {p_root, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k]  <= p_val << 2;
				side_s[k] <= p_side;
				if (t_rem >= trial) begin
					rem_s[k]  <= t_rem - trial;
					root_s[k] <= {p_root[CB-2:0], 1'b1};
				end else begin
					rem_s[k]  <= t_rem;
					root_s[k] <= {p_root[CB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[CB-1];
	assign root      = root_s[CB-1];
	assign out_side  = side_s[CB-1];

endmodule

// ===== design/lpri_cordic.sv =====
`timescale 1ns / 1ps

module lpri_cordic #(
	parameter int CB = 24,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [CB-1:0]        h,
	input  logic signed [CB-1:0] z,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output lpri_pkg::ang_t       angle,
	output logic [SW-1:0]        out_side
);
	import lpri_pkg::*;

	localparam int XW = CB + PRE_SH + 3;

	logic                 vld_s  [CORDIC_STEPS];
	logic signed [XW-1:0] cx_s   [CORDIC_STEPS];
	logic signed [XW-1:0] cy_s   [CORDIC_STEPS];
	ang_t                 acc_s  [CORDIC_STEPS];
	logic [SW-1:0]        side_s [CORDIC_STEPS];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic                 p_vld;
		logic signed [XW-1:0] p_x;
		logic signed [XW-1:0] p_y;
		ang_t                 p_acc;
		logic [SW-1:0]        p_side;
		logic signed [XW-1:0] dx;
		logic signed [XW-1:0] dy;

		if (i == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_x    = $signed({{(XW-CB-PRE_SH){1'b0}}, h, {PRE_SH{1'b0}}});
			assign p_y    = $signed({{(XW-CB-PRE_SH){z[CB-1]}}, z, {PRE_SH{1'b0}}});
			assign p_acc  = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_vld  = vld_s[i-1];
			assign p_x    = cx_s[i-1];
			assign p_y    = cy_s[i-1];
			assign p_acc  = acc_s[i-1];
			assign p_side = side_s[i-1];
		end

		assign dx = p_y >>> i;
		assign dy = p_x >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= p_side;
				if (!p_y[XW-1]) begin
					cx_s[i]  <= p_x + dx;
					cy_s[i]  <= p_y - dy;
					acc_s[i] <= p_acc + ATAN_TAB[i];
				end else begin
					cx_s[i]  <= p_x - dx;
					cy_s[i]  <= p_y + dy;
					acc_s[i] <= p_acc - ATAN_TAB[i];
				end
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS-1];
	assign angle     = acc_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];

endmodule

// ===== design/lpri_div.sv =====
`timescale 1ns / 1ps

module lpri_div #(
	parameter int PW = 32,
	parameter int DW = 24,
	parameter int QB = 6,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [PW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic          ovf,
	output logic [QB-1:0] quot,
	output logic [SW-1:0] out_side
);

	localparam int CW = PW + DW + QB;

	logic          vld_s1;
	logic          ovf_s1;
	logic [CW-1:0] rem_s1;
	logic [DW-1:0] dvs_s1;
	logic [SW-1:0] side_s1;

	logic          vld_s  [QB];
	logic          ovf_s  [QB];
	logic [CW-1:0] rem_s  [QB];
	logic [DW-1:0] dvs_s  [QB];
	logic [QB-1:0] q_s    [QB];
	logic [SW-1:0] side_s [QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s1  <= CW'(dividend) >= (CW'(divisor) << QB);
			rem_s1  <= CW'(dividend);
			dvs_s1  <= divisor;
			side_s1 <= in_side;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_bit
		logic          p_vld;
		logic          p_ovf;
		logic [CW-1:0] p_rem;
		logic [DW-1:0] p_dvs;
		logic [QB-1:0] p_q;
		logic [SW-1:0] p_side;
		logic [CW-1:0] sh;

		if (k == 0) begin : g_first
			assign p_vld  = vld_s1;
			assign p_ovf  = ovf_s1;
			assign p_rem  = rem_s1;
			assign p_dvs  = dvs_s1;
			assign p_q    = '0;
			assign p_side = side_s1;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_ovf  = ovf_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_dvs  = dvs_s[k-1];
			assign p_q    = q_s[k-1];
			assign p_side = side_s[k-1];
		end

		assign sh = CW'(p_dvs) << (QB - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[k]  <= p_ovf;
				dvs_s[k]  <= p_dvs;
				side_s[k] <= p_side;
				if (p_rem >= sh) begin
					rem_s[k] <= p_rem - sh;
					q_s[k]   <= p_q | (QB'(1) << (QB - 1 - k));
				end else begin
					rem_s[k] <= p_rem;
					q_s[k]   <= p_q;
				end
			end
		end
	end

	assign out_valid = vld_s[QB-1];
	assign ovf       = ovf_s[QB-1];
	assign quot      = q_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

// ===== design/lidar_point_ring_index_top.sv =====
`timescale 1ns / 1ps

// Lidar point ring indexer. Takes one point per clock while the output is not
// stalled and returns it with its 16-bit intensity and the elevation row
// (ring_index), one result per point, in order. The pipe runs through the
// one-bit-per-stage square root, the 23 CORDIC stages and the one-bit-per-stage
// row divider. A stall on the output freezes the whole pipe; in_ready is low
// only while the last stage holds an item that is not taken. Write the
// configuration registers only while the pipe is empty.

module lidar_point_ring_index_top #(
	parameter int MAX_ROWS   = 64,
	parameter int COORD_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lpri_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpri_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_BITS-1:0]       x_coord,
	input  logic signed [COORD_BITS-1:0]       y_coord,
	input  logic signed [COORD_BITS-1:0]       z_coord,
	input  logic [31:0]                        colour_word,
	input  logic                               last_point,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_BITS-1:0]       x_out,
	output logic signed [COORD_BITS-1:0]       y_out,
	output logic signed [COORD_BITS-1:0]       z_out,
	output logic [15:0]                        intensity,
	output logic [5:0]                         ring_index,
	output logic                               last_out
);
	import lpri_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int RB = $clog2(MAX_ROWS + 1);
	localparam int QB = $clog2(MAX_ROWS);
	localparam int DW = CFG_DATA_W + 8;
	localparam int NW = ANG_W + 1;
	localparam int PW = ANG_W + RB;

	typedef struct packed {
		logic          org;
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] z;
		logic [15:0]   inten;
		logic          last;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	logic [14:0] lower_q;
	logic [15:0] span_q;
	logic [6:0]  rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= 15'd4480;
			span_q  <= 16'd8960;
			rows_q  <= 7'd56;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOWER: lower_q <= cfg_data[14:0];
				REG_SPAN:  span_q  <= cfg_data;
				REG_ROWS:  rows_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	logic [RB-1:0] rows_eff;
	logic [RB-1:0] rows_m1;
	logic [15:0]   span_eff;
	logic [DW-1:0] dvs;

	always_comb begin
		if (rows_q == 7'd0) begin
			rows_eff = RB'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			rows_eff = RB'(MAX_ROWS);
		end else begin
			rows_eff = RB'(rows_q);
		end
	end

	assign rows_m1  = rows_eff - RB'(1);
	assign span_eff = (span_q == 16'd0) ? 16'd1 : span_q;
	assign dvs      = {span_eff, 8'b0};

	logic en;
	logic vld_s6;

	assign en       = !vld_s6 || out_ready;
	assign in_ready = en;

	// stage 1: magnitudes
	logic          vld_s1;
	logic [CB-1:0] ax_s1;
	logic [CB-1:0] ay_s1;
	side_t         side_s1;

	// stage 2: squares
	logic            vld_s2;
	logic [2*CB-1:0] sqx_s2;
	logic [2*CB-1:0] sqy_s2;
	side_t           side_s2;

	// stage 3: sum
	logic            vld_s3;
	logic [2*CB-1:0] sum_s3;
	side_t           side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1         <= x_coord[CB-1] ? CB'(-x_coord) : x_coord;
			ay_s1         <= y_coord[CB-1] ? CB'(-y_coord) : y_coord;
			side_s1.org   <= (x_coord == '0) && (y_coord == '0) && (z_coord == '0);
			side_s1.x     <= x_coord;
			side_s1.y     <= y_coord;
			side_s1.z     <= z_coord;
			side_s1.inten <= colour_word[15:0];
			side_s1.last  <= last_point;

			sqx_s2  <= (2*CB)'(ax_s1) * (2*CB)'(ax_s1);
			sqy_s2  <= (2*CB)'(ay_s1) * (2*CB)'(ay_s1);
			side_s2 <= side_s1;

			sum_s3  <= sqx_s2 + sqy_s2;
			side_s3 <= side_s2;
		end
	end

	logic              vld_sq;
	logic [CB-1:0]     h_sq;
	logic [SIDE_W-1:0] side_sq;
	side_t             sq_side;

	lpri_isqrt #(
		.CB(CB),
		.SW(SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.radicand (sum_s3),
		.in_side  (side_s3),
		.out_valid(vld_sq),
		.root     (h_sq),
		.out_side (side_sq)
	);

	assign sq_side = side_t'(side_sq);

	logic              vld_ang;
	ang_t              ang;
	logic [SIDE_W-1:0] side_ang;

	lpri_cordic #(
		.CB(CB),
		.SW(SIDE_W)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_sq),
		.h        (h_sq),
		.z        (sq_side.z),
		.in_side  (side_sq),
		.out_valid(vld_ang),
		.angle    (ang),
		.out_side (side_ang)
	);

	// stage 4: offset; stage 5: scale by rows
	logic                 vld_s4;
	logic signed [NW-1:0] num_s4;
	side_t                side_s4;
	logic                 vld_s5;
	logic                 neg_s5;
	logic [PW-1:0]        prod_s5;
	side_t                side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_ang;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= {ang[ANG_W-1], ang} + $signed({{(NW-23){1'b0}}, lower_q, 8'b0});
			side_s4 <= side_t'(side_ang);
			neg_s5  <= num_s4[NW-1];
			prod_s5 <= PW'(num_s4[ANG_W-1:0]) * PW'(rows_eff);
			side_s5 <= side_s4;
		end
	end

	logic                vld_dv;
	logic                ovf_dv;
	logic [QB-1:0]       q_dv;
	logic [SIDE_W:0]     side_dv;
	side_t               dv_side;
	logic                neg_dv;

	lpri_div #(
		.PW(PW),
		.DW(DW),
		.QB(QB),
		.SW(SIDE_W + 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.dividend (prod_s5),
		.divisor  (dvs),
		.in_side  ({neg_s5, side_s5}),
		.out_valid(vld_dv),
		.ovf      (ovf_dv),
		.quot     (q_dv),
		.out_side (side_dv)
	);

	assign neg_dv  = side_dv[SIDE_W];
	assign dv_side = side_t'(side_dv[SIDE_W-1:0]);

	// stage 6: clamp and output register
	logic [RB-1:0] ring_s6;
	side_t         side_s6;
	logic [RB-1:0] ring_d;
	logic [RB+5:0] ring_w;

	always_comb begin
		if (dv_side.org) begin
			ring_d = rows_m1;
		end else if (neg_dv) begin
			ring_d = '0;
		end else if (ovf_dv || (RB'(q_dv) > rows_m1)) begin
			ring_d = rows_m1;
		end else begin
			ring_d = RB'(q_dv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s6 <= ring_d;
			side_s6 <= dv_side;
		end
	end

	assign ring_w     = (RB + 6)'(ring_s6);
	assign out_valid  = vld_s6;
	assign x_out      = side_s6.x;
	assign y_out      = side_s6.y;
	assign z_out      = side_s6.z;
	assign intensity  = side_s6.inten;
	assign ring_index = ring_w[5:0];
	assign last_out   = side_s6.last;

endmodule

// ===== design/lpri_checker.sv =====
`timescale 1ns / 1ps

module lpri_checker #(
	parameter int MAX_ROWS   = 64,
	parameter int COORD_BITS = 24
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [lpri_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [lpri_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [COORD_BITS-1:0]           x_out,
	input logic [5:0]                      ring_index
);
	import lpri_pkg::*;

	logic [6:0] rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd56;
		end else if (cfg_we && cfg_index == REG_ROWS) begin
			rows_q <= cfg_data[6:0];
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(ring_index) && $stable(x_out))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rows_q != 7'd0 && int'(rows_q) <= MAX_ROWS && rows_q <= 7'd64
		|-> {1'b0, ring_index} < rows_q)
		else $error("ring index beyond row count");

	a_ring_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (rows_q == 7'd0 || rows_q == 7'd1) |-> ring_index == 6'd0)
		else $error("ring index nonzero with a single row");

endmodule

bind lidar_point_ring_index_top lpri_checker #(
	.MAX_ROWS  (MAX_ROWS),
	.COORD_BITS(COORD_BITS)
) u_lpri_checker (.*);

// ===== tb/tb_lidar_point_ring_index_top.sv =====
`timescale 1ns / 1ps

module tb_lidar_point_ring_index_top;
	import lpri_pkg::*;

	localparam int CW = 24;
	localparam int LATENCY = 60;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [31:0]          colour;
		logic                 last;
	} point_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [15:0]          inten;
		logic [5:0]           ring;
		logic                 last;
	} ringed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] x_coord = '0, y_coord = '0, z_coord = '0;
	logic [31:0] colour_word = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] x_out, y_out, z_out;
	logic [15:0] intensity;
	logic [5:0] ring_index;
	logic last_out;

	lidar_point_ring_index_top i_dut (.*);

	always #6 clk = ~clk;

	// configuration mirror
	longint lower_lim = 4480, span_reg = 8960, rows_reg = 56;

	point_t pending_pts[$];
	ringed_t expected_rings[$];
	int mismatches = 0;
	int hold_cycles = 0;
	bit rx_quiet = 0;

	localparam longint ATAN_DEG [23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned rem, res, b;
		rem = v; res = 0; b = 64'd1 << 62;
		while (b > rem) b >>= 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic ringed_t project_point(point_t p);
		ringed_t r;
		longint x, y, z, h, cx, cy, acc, dx, dy, num;
		longint unsigned rows, span, ring;
		x = p.x; y = p.y; z = p.z;
		rows = rows_reg == 0 ? 1 : (rows_reg > 64 ? 64 : rows_reg);
		span = span_reg == 0 ? 1 : span_reg;
		if (x == 0 && y == 0 && z == 0) begin
			ring = rows - 1;
		end else begin
			if (x < 0) x = -x;
			if (y < 0) y = -y;
			h = int_sqrt(x * x + y * y);
			cx = h * 65536; cy = z * 65536; acc = 0;
			for (int i = 0; i < 23; i++) begin
				dx = floor_shift(cy, i);
				dy = floor_shift(cx, i);
				if (cy >= 0) begin
					cx += dx; cy -= dy; acc += ATAN_DEG[i];
				end else begin
					cx -= dx; cy += dy; acc -= ATAN_DEG[i];
				end
			end
			num = acc + lower_lim * 256;
			if (num < 0) ring = 0;
			else ring = (longint'(num) * rows) / (span * 256);
			if (ring > rows - 1) ring = rows - 1;
		end
		r.x = p.x; r.y = p.y; r.z = p.z;
		r.inten = p.colour[15:0];
		r.ring = ring[5:0];
		r.last = p.last;
		return r;
	endfunction

	// driver
	int tx_gap = 0;
	always @(posedge clk) begin
		point_t p;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_rings.push_back(project_point(pending_pts.pop_front()));
				tx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
			end
			if ((!in_valid || in_ready) ) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_pts.size() > 0) begin
					p = pending_pts[0];
					in_valid <= 1'b1;
					x_coord <= p.x; y_coord <= p.y; z_coord <= p.z;
					colour_word <= p.colour; last_point <= p.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int rx_gap = 0;
	always @(posedge clk) begin
		ringed_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_rings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected item x=%0d", x_out);
				end else begin
					e = expected_rings.pop_front();
					if (x_out !== e.x || y_out !== e.y || z_out !== e.z ||
					    intensity !== e.inten || ring_index !== e.ring ||
					    last_out !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp %0d %0d %0d %h ring %0d last %b, ",
								"got %0d %0d %0d %h ring %0d last %b"},
								e.x, e.y, e.z, e.inten, e.ring, e.last,
								x_out, y_out, z_out, intensity, ring_index, last_out);
					end
				end
				rx_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0 && !rx_quiet) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CW'($urandom_range(0, 63) - 32);
			1: return CW'($urandom_range(0, 4095) - 2048);
			2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord();
		if ($urandom_range(0, 9) == 0) p.z = 0;
		if ($urandom_range(0, 4) == 0) begin
			p.x = CW'($urandom_range(0, 2000) - 1000);
			p.y = CW'($urandom_range(0, 2000) - 1000);
			p.z = CW'($urandom_range(0, 200) - 100);
		end
		p.colour = $urandom;
		p.last = $urandom_range(0, 15) == 0;
		return p;
	endfunction

	function automatic point_t mk(longint x, longint y, longint z, logic [31:0] c, logic l);
		point_t p;
		p.x = CW'(x); p.y = CW'(y); p.z = CW'(z); p.colour = c; p.last = l;
		return p;
	endfunction

	task automatic drain();
		while (pending_pts.size() > 0 || in_valid || expected_rings.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, longint val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LOWER: lower_lim = val & 16'h7FFF;
			REG_SPAN:  span_reg  = val & 16'hFFFF;
			REG_ROWS:  rows_reg  = val & 16'h7F;
			default: ;
		endcase
	endtask

	task automatic set_cfg(longint lo, longint sp, longint rw);
		write_cfg(REG_LOWER, lo);
		write_cfg(REG_SPAN, sp);
		write_cfg(REG_ROWS, rw);
	endtask

	task automatic random_batch(int n);
		repeat (n) pending_pts.push_back(rand_point());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed, reset configuration
		pending_pts.push_back(mk(0, 0, 0, 32'hFFFF_FFFF, 1));
		pending_pts.push_back(mk(0, 0, 0, 32'h0000_0000, 0));
		pending_pts.push_back(mk(8388607, 8388607, 8388607, 32'hA5A5_5A5A, 0));
		pending_pts.push_back(mk(-8388608, -8388608, -8388608, 32'h5A5A_A5A5, 1));
		pending_pts.push_back(mk(1000, 0, 0, 32'h1234_5678, 0));
		pending_pts.push_back(mk(0, 0, 1, 32'h0, 0));
		pending_pts.push_back(mk(0, 0, -1, 32'h0, 0));
		pending_pts.push_back(mk(10000, 0, 5000, 32'h0, 0));
		pending_pts.push_back(mk(10000, 0, -5000, 32'h0, 0));
		pending_pts.push_back(mk(-3, 4, 0, 32'hFFFF_0000, 1));
		pending_pts.push_back(mk(1024, -1024, 300, 32'h0000_FFFF, 0));
		pending_pts.push_back(mk(0, -8388608, 0, 32'h8000_0001, 0));
		drain();
		// zero span and zero rows
		set_cfg(0, 0, 0);
		pending_pts.push_back(mk(100, 0, 10, 32'h1, 0));
		pending_pts.push_back(mk(0, 0, 0, 32'h2, 1));
		random_batch(20);
		drain();
		// rows above limit, widest view
		set_cfg(23040, 46080, 127);
		pending_pts.push_back(mk(0, 0, 0, 32'h3, 0));
		pending_pts.push_back(mk(100, 0, -100000, 32'h4, 0));
		pending_pts.push_back(mk(100, 0, 100000, 32'h5, 1));
		random_batch(300);
		drain();
		// full lower and span register range, rows at the limit
		set_cfg(32767, 65535, 64);
		random_batch(300);
		// receiver holds off while the sender keeps offering
		hold_cycles = 300;
		drain();
		set_cfg(0, 1, 1);
		random_batch(200);
		drain();
		set_cfg(4480, 8960, 56);
		rx_quiet = 1;
		random_batch(200);
		drain();
		rx_quiet = 0;
		set_cfg($urandom_range(0, 23040), $urandom_range(1, 46080), $urandom_range(1, 64));
		random_batch(300);
		drain();
		if (mismatches == 0 && expected_rings.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
